[sv/c3f_pkg.sv]
// ----------------------------------------------------------------------------
// c3f_pkg
// Shared types and constants for the 3x3 saturating convolution filter.
// ----------------------------------------------------------------------------
`default_nettype none

package c3f_pkg;

  // Geometry limits and derived widths
  localparam int unsigned C3F_MAX_WIDTH  = 1024;
  localparam int unsigned C3F_MAX_HEIGHT = 1024;
  localparam int unsigned C3F_ADDR_W     = $clog2(C3F_MAX_WIDTH);
  localparam int unsigned C3F_DIM_W      = 11;
  localparam int unsigned C3F_KROW_W     = 48;
  localparam int unsigned C3F_COEF_W     = 16;
  localparam int unsigned C3F_CFG_IDX_W  = 3;

  // Line store entry: {older row, newer row}
  localparam int unsigned C3F_LINE_W     = 16;

  // Product, row sum and total sum widths
  localparam int unsigned C3F_PROD_W     = C3F_COEF_W + 9;
  localparam int unsigned C3F_ROW_W      = C3F_PROD_W + 2;
  localparam int unsigned C3F_SUM_W      = C3F_ROW_W + 1;

  // Configuration register indexes
  typedef enum logic [C3F_CFG_IDX_W-1:0] {
    C3F_REG_WIDTH  = 3'd0,
    C3F_REG_HEIGHT = 3'd1,
    C3F_REG_KTOP   = 3'd2,
    C3F_REG_KMID   = 3'd3,
    C3F_REG_KBOT   = 3'd4
  } c3f_reg_t;

  // Input operation codes
  localparam logic C3F_OP_PIXEL = 1'b0;
  localparam logic C3F_OP_DRAIN = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [7:0] pixel_in;
  } c3f_in_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       last_of_frame;
  } c3f_out_t;

  // 3x3 window, entry r*3+c, row 0 on top, column 0 on the left
  typedef logic [8:0][7:0] c3f_win_t;

  // Kernel rows, row 0 on top
  typedef logic [2:0][C3F_KROW_W-1:0] c3f_kern_t;

  // Per-result control travelling alongside the arithmetic
  typedef struct packed {
    logic       border;
    logic       last;
    logic [7:0] center;
  } c3f_tag_t;

endpackage

`default_nettype wire

[sv/c3f_line_mem.sv]
// ----------------------------------------------------------------------------
// c3f_line_mem
// Simple dual-port synchronous RAM, one write and one read port, registered
// read data. A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module c3f_line_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[sv/c3f_mac.sv]
// ----------------------------------------------------------------------------
// c3f_mac
// Three-stage multiply-accumulate and clamp: nine products, three row sums,
// then the final sum, clamp to 0..255 and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module c3f_mac (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              mac_valid,
  output logic                   mac_ready,
  input  wire c3f_pkg::c3f_win_t  mac_win,
  input  wire c3f_pkg::c3f_tag_t  mac_tag,
  input  wire c3f_pkg::c3f_kern_t kern,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output c3f_pkg::c3f_out_t      out_data
);
  import c3f_pkg::*;

  logic                           s2_valid_r;
  logic signed [C3F_PROD_W-1:0]   prod_r   [9];
  logic signed [C3F_PROD_W-1:0]   prod_nxt [9];
  c3f_tag_t                       s2_tag_r;

  logic                           s3_valid_r;
  logic signed [C3F_ROW_W-1:0]    row_r   [3];
  logic signed [C3F_ROW_W-1:0]    row_nxt [3];
  c3f_tag_t                       s3_tag_r;

  logic                           out_valid_r;
  logic [7:0]                     out_pix_r;
  logic [7:0]                     out_pix_nxt;
  logic                           out_last_r;
  logic signed [C3F_SUM_W-1:0]    sum;

  logic s2_ready, s3_ready, s4_ready;

  assign s4_ready  = !out_valid_r || out_ready;
  assign s3_ready  = !s3_valid_r || s4_ready;
  assign s2_ready  = !s2_valid_r || s3_ready;
  assign mac_ready = s2_ready;

  // Products: signed coefficient times unsigned pixel
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      prod_nxt[i] = $signed(kern[i / 3][(i % 3) * C3F_COEF_W +: C3F_COEF_W]) *
                    $signed({1'b0, mac_win[i]});
    end
  end

  // Row sums
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row_nxt[r] = C3F_ROW_W'(prod_r[r*3]) + C3F_ROW_W'(prod_r[r*3+1]) +
                   C3F_ROW_W'(prod_r[r*3+2]);
    end
  end

  // Final sum and clamp; border pixels pass the center through
  always_comb begin
    sum = C3F_SUM_W'(row_r[0]) + C3F_SUM_W'(row_r[1]) + C3F_SUM_W'(row_r[2]);
    if (s3_tag_r.border) begin
      out_pix_nxt = s3_tag_r.center;
    end else if (sum < 0) begin
      out_pix_nxt = 8'd0;
    end else if (sum > C3F_SUM_W'(255)) begin
      out_pix_nxt = 8'd255;
    end else begin
      out_pix_nxt = sum[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s2_ready) begin
        s2_valid_r <= mac_valid;
      end
      if (s3_ready) begin
        s3_valid_r <= s2_valid_r;
      end
      if (s4_ready) begin
        out_valid_r <= s3_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mac_valid && s2_ready) begin
      prod_r   <= prod_nxt;
      s2_tag_r <= mac_tag;
    end
    if (s2_valid_r && s3_ready) begin
      row_r    <= row_nxt;
      s3_tag_r <= s2_tag_r;
    end
    if (s3_valid_r && s4_ready) begin
      out_pix_r  <= out_pix_nxt;
      out_last_r <= s3_tag_r.last;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_data.pixel_out     = out_pix_r;
  assign out_data.last_of_frame = out_last_r;

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_pix_r) && $stable(out_last_r))
    else $error("output word changed while stalled");

  // A stage with a word waiting downstream never drops it
  a_s3_keep: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid_r && !s4_ready |=> s3_valid_r)
    else $error("row-sum stage lost a word");

  a_s2_keep: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && !s3_ready |=> s2_valid_r)
    else $error("product stage lost a word");

endmodule

`default_nettype wire

[sv/conv3x3_saturating_filter_core.sv]
// ----------------------------------------------------------------------------
// conv3x3_saturating_filter_core
// 3x3 saturating convolution over a raster stream of 8-bit gray pixels.
// ----------------------------------------------------------------------------
// Takes one word per clock on the input channel unless the result side
// stalls, and gives at most one result word per clock. The two previous
// image rows live in a single 1024 x 16 line memory (older row in the upper
// byte, newer row in the lower byte) with a registered read: a word reads its
// column at acceptance, and in the window stage that follows it shifts the
// 3x3 window, writes the column back and hands the window to a three-stage
// multiply/sum/clamp pipeline, where its result is registered as products,
// row sums and output, held while the output side stalls. Unstalled, the
// sustained rate is one word per clock, set by the line memory's single read
// and single write per cycle; when two back-to-back words hit the same
// column (width 1) the write data is forwarded. Interior pixels get the
// clamped correlation with the nine signed 16-bit kernel coefficients, border
// pixels are copied. Results trail their inputs by W+1 words; after the last
// pixel of a frame send W+1 drain words (operation = 1) to flush the frame;
// the final result carries last_of_frame. Drain words sent while a frame is
// still arriving are consumed with no effect, and pixels sent after the
// frame's last pixel act as drain words. Write configuration only while the
// block is idle; a write to the width or height register restarts frame
// position. The line memory is not cleared at reset.
// ----------------------------------------------------------------------------
`default_nettype none

module conv3x3_saturating_filter_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire c3f_pkg::c3f_in_t                    in_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output c3f_pkg::c3f_out_t                       out_data,
  input  wire logic                               cfg_we,
  input  wire logic [c3f_pkg::C3F_CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [c3f_pkg::C3F_KROW_W-1:0]     cfg_wdata
);
  import c3f_pkg::*;

  localparam logic [C3F_DIM_W-1:0]  MAX_W_DIM = C3F_DIM_W'(C3F_MAX_WIDTH);
  localparam logic [C3F_DIM_W-1:0]  MAX_H_DIM = C3F_DIM_W'(C3F_MAX_HEIGHT);
  localparam logic [C3F_ADDR_W-1:0] LAST_COL  = C3F_ADDR_W'(C3F_MAX_WIDTH - 1);

  // Configuration registers
  logic [C3F_DIM_W-1:0] width_r, height_r;
  c3f_kern_t            kern_r;

  // Frame position
  logic [C3F_DIM_W-1:0] in_col_r, in_row_r, out_col_r, out_row_r;
  logic [C3F_DIM_W-1:0] in_col_nxt, in_row_nxt, out_col_nxt, out_row_nxt;

  // Geometry in use
  logic [C3F_DIM_W-1:0] eff_w, eff_h, w_last, h_last;

  // Accept stage
  logic                  accept, input_done, ignore, step;
  logic [7:0]            px0;
  logic [C3F_ADDR_W-1:0] col_addr;
  logic                  emit0, border0, last0;

  // Window-update stage (line memory read data is valid here)
  logic                  s1_valid_r;
  logic [C3F_ADDR_W-1:0] s1_addr_r;
  logic [7:0]            s1_px_r;
  logic                  s1_emit_r;
  logic                  s1_border_r;
  logic                  s1_last_r;
  logic                  s1_fire;
  logic                  fwd_r;
  logic [C3F_LINE_W-1:0] fwd_data_r;
  logic [C3F_LINE_W-1:0] ls_rd;
  logic [C3F_LINE_W-1:0] ls_eff;
  logic [C3F_LINE_W-1:0] ls_wr_data;
  logic                  fwd_hit;

  c3f_win_t window_r, window_nxt;
  c3f_tag_t mac_tag;
  logic     mac_valid, mac_ready;

  // Clamp the programmed geometry to 1..MAX
  always_comb begin
    if (width_r == '0) begin
      eff_w = C3F_DIM_W'(1);
    end else if (width_r > MAX_W_DIM) begin
      eff_w = MAX_W_DIM;
    end else begin
      eff_w = width_r;
    end
    if (height_r == '0) begin
      eff_h = C3F_DIM_W'(1);
    end else if (height_r > MAX_H_DIM) begin
      eff_h = MAX_H_DIM;
    end else begin
      eff_h = height_r;
    end
    w_last = eff_w - C3F_DIM_W'(1);
    h_last = eff_h - C3F_DIM_W'(1);
  end

  // Accept a word whenever the window stage is free or moving on
  assign in_ready = !s1_valid_r || s1_fire;
  assign accept   = in_valid && in_ready;

  assign input_done = in_row_r >= eff_h;
  // Drop drain words that arrive while the frame is still coming in
  assign ignore     = (in_data.operation == C3F_OP_DRAIN) && !input_done;
  assign step       = accept && !ignore;
  assign px0        = input_done ? 8'd0 : in_data.pixel_in;
  assign col_addr   = (in_col_r > C3F_DIM_W'(LAST_COL)) ? LAST_COL
                                                        : in_col_r[C3F_ADDR_W-1:0];

  assign emit0   = (in_row_r >= C3F_DIM_W'(2)) ||
                   ((in_row_r == C3F_DIM_W'(1)) && (in_col_r != '0));
  assign border0 = (out_row_r == '0) || (out_row_r >= h_last) ||
                   (out_col_r == '0) || (out_col_r >= w_last);
  assign last0   = (out_row_r >= h_last) && (out_col_r >= w_last);

  // Advance the position counters
  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (step) begin
      if (in_col_r >= w_last) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + C3F_DIM_W'(1);
      end else begin
        in_col_nxt = in_col_r + C3F_DIM_W'(1);
      end
      if (emit0) begin
        if (last0) begin
          // Frame done: restart every position counter
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end else if (out_col_r >= w_last) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + C3F_DIM_W'(1);
        end else begin
          out_col_nxt = out_col_r + C3F_DIM_W'(1);
        end
      end
    end
    if (cfg_we && (cfg_index == C3F_REG_WIDTH || cfg_index == C3F_REG_HEIGHT)) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= MAX_W_DIM;
      height_r  <= MAX_H_DIM;
      kern_r[0] <= 48'h0000_0001_0000;
      kern_r[1] <= 48'h0001_FFFB_0001;
      kern_r[2] <= 48'h0000_0001_0000;
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          C3F_REG_WIDTH:  width_r   <= cfg_wdata[C3F_DIM_W-1:0];
          C3F_REG_HEIGHT: height_r  <= cfg_wdata[C3F_DIM_W-1:0];
          C3F_REG_KTOP:   kern_r[0] <= cfg_wdata;
          C3F_REG_KMID:   kern_r[1] <= cfg_wdata;
          C3F_REG_KBOT:   kern_r[2] <= cfg_wdata;
          default: ;
        endcase
      end
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  // Window stage: a non-emitting word only updates the window and memory
  assign s1_fire = s1_valid_r && (!s1_emit_r || mac_ready);

  // Take the previous word's write data when it hit the same column
  assign ls_eff     = fwd_r ? fwd_data_r : ls_rd;
  assign ls_wr_data = {ls_eff[7:0], s1_px_r};
  assign fwd_hit    = s1_fire && (s1_addr_r == col_addr);

  c3f_line_mem #(
    .DEPTH (C3F_MAX_WIDTH),
    .WIDTH (C3F_LINE_W)
  ) u_line_mem (
    .clk     (clk),
    .wr_en   (s1_fire),
    .wr_addr (s1_addr_r),
    .wr_data (ls_wr_data),
    .rd_en   (step),
    .rd_addr (col_addr),
    .rd_data (ls_rd)
  );

  // Shift the window left and bring in the new column
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      window_nxt[r*3]   = window_r[r*3+1];
      window_nxt[r*3+1] = window_r[r*3+2];
    end
    window_nxt[2] = ls_eff[15:8];
    window_nxt[5] = ls_eff[7:0];
    window_nxt[8] = s1_px_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
      window_r   <= '0;
    end else begin
      if (step) begin
        s1_valid_r <= 1'b1;
        fwd_r      <= fwd_hit;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
        fwd_r      <= 1'b0;
      end
      if (s1_fire) begin
        window_r <= window_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      s1_addr_r   <= col_addr;
      s1_px_r     <= px0;
      s1_emit_r   <= emit0;
      s1_border_r <= border0;
      s1_last_r   <= last0;
      fwd_data_r  <= ls_wr_data;
    end
  end

  assign mac_valid      = s1_valid_r && s1_emit_r;
  assign mac_tag.border = s1_border_r;
  assign mac_tag.last   = s1_last_r;
  assign mac_tag.center = window_nxt[4];

  c3f_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .mac_valid (mac_valid),
    .mac_ready (mac_ready),
    .mac_win   (window_nxt),
    .mac_tag   (mac_tag),
    .kern      (kern_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Forwarding is only armed for a word sitting in the window stage
  a_fwd_live: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> s1_valid_r)
    else $error("forward flag set with window stage empty");

  // A held word keeps its line memory read data
  a_rd_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_fire |=> $stable(ls_rd))
    else $error("line memory read data changed under a held word");

  // Column positions stay inside the row in use
  a_in_col: assert property (@(posedge clk) disable iff (!rst_n)
    in_col_r <= w_last)
    else $error("input column past row end");

  a_out_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_col_r <= w_last)
    else $error("output column past row end");

endmodule

`default_nettype wire

[sim/conv3x3_saturating_filter_core_tb.sv]
// ----------------------------------------------------------------------------
// conv3x3_saturating_filter_core_tb
// Self-checking bench for the 3x3 saturating convolution core.
// ----------------------------------------------------------------------------
// Streams random and hand-picked frames through the input channel with random
// gaps and random output back-pressure. A scoreboard mirrors the filter
// (line rows, 3x3 window, frame counters, geometry and kernel registers) and
// lines up the expected result words, which are checked field by field as
// they leave the block. Geometry and kernel registers change only while the
// block is idle, between frames or after an aborted partial frame.
// ----------------------------------------------------------------------------

module conv3x3_saturating_filter_core_tb;

  import c3f_pkg::*;

  // Number of architected registers; indexes at or above this are ignored by the block
  localparam int NUM_CFG_REGS = 5;
  // Cycles to let a word that produces no result leave the pipeline
  localparam int SETTLE_CYCLES = 16;
  // Consecutive cycles with no handshake on either side before giving up
  localparam int QUIET_LIMIT = 2000;
  // Words (not counting ignored drains) to push before the tall frame
  localparam int unsigned STREAM_GOAL = 260;

  // Mirror of the filter: predicts the result word, if any, for each consumed input word
  class conv_scoreboard;
    logic [C3F_DIM_W-1:0] width_reg;
    logic [C3F_DIM_W-1:0] height_reg;
    c3f_kern_t            kern;
    logic [7:0]           older_row [C3F_MAX_WIDTH];
    logic [7:0]           newer_row [C3F_MAX_WIDTH];
    logic [7:0]           win [3][3];
    int unsigned          in_col, in_row, out_col, out_row;
    c3f_out_t             expected_pixels [$];
    int unsigned          consumed;
    int unsigned          errors;

    function new();
      width_reg  = C3F_DIM_W'(C3F_MAX_WIDTH);
      height_reg = C3F_DIM_W'(C3F_MAX_HEIGHT);
      kern[0]    = 48'h0000_0001_0000;
      kern[1]    = 48'h0001_FFFB_0001;
      kern[2]    = 48'h0000_0001_0000;
      foreach (older_row[i]) begin
        older_row[i] = '0;
        newer_row[i] = '0;
      end
      foreach (win[r, c]) win[r][c] = '0;
      consumed = 0;
      errors   = 0;
      restart();
    endfunction

    function void restart();
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
    endfunction

    function int unsigned eff_w();
      if (width_reg == 0) return 1;
      if (width_reg > C3F_MAX_WIDTH) return C3F_MAX_WIDTH;
      return int'(width_reg);
    endfunction

    function int unsigned eff_h();
      if (height_reg == 0) return 1;
      if (height_reg > C3F_MAX_HEIGHT) return C3F_MAX_HEIGHT;
      return int'(height_reg);
    endfunction

    function void write_reg(logic [C3F_CFG_IDX_W-1:0] idx, logic [C3F_KROW_W-1:0] value);
      case (idx)
        C3F_REG_WIDTH: begin
          width_reg = value[C3F_DIM_W-1:0];
          restart();
        end
        C3F_REG_HEIGHT: begin
          height_reg = value[C3F_DIM_W-1:0];
          restart();
        end
        C3F_REG_KTOP: kern[0] = value;
        C3F_REG_KMID: kern[1] = value;
        C3F_REG_KBOT: kern[2] = value;
        default: ;
      endcase
    endfunction

    function void take_word(c3f_in_t word);
      int unsigned w, h, col;
      logic        frame_in;
      logic        fire;
      logic [7:0]  px;
      int          sum;
      c3f_out_t    res;
      w = eff_w();
      h = eff_h();
      frame_in = (in_row >= h);
      // drop drains while the frame is still arriving
      if (word.operation == C3F_OP_DRAIN && !frame_in) return;
      consumed++;
      px  = frame_in ? 8'd0 : word.pixel_in;
      col = (in_col < C3F_MAX_WIDTH) ? in_col : C3F_MAX_WIDTH - 1;
      for (int r = 0; r < 3; r++) begin
        win[r][0] = win[r][1];
        win[r][1] = win[r][2];
      end
      win[0][2] = older_row[col];
      win[1][2] = newer_row[col];
      win[2][2] = px;
      older_row[col] = newer_row[col];
      newer_row[col] = px;
      fire = (in_row >= 2) || (in_row == 1 && in_col >= 1);
      if (in_col + 1 >= w) begin
        in_col = 0;
        in_row++;
      end else begin
        in_col++;
      end
      if (!fire) return;
      if (out_row == 0 || out_row + 1 >= h || out_col == 0 || out_col + 1 >= w) begin
        res.pixel_out = win[1][1];
      end else begin
        sum = 0;
        for (int r = 0; r < 3; r++)
          for (int c = 0; c < 3; c++)
            sum += int'($signed(kern[r][c*C3F_COEF_W +: C3F_COEF_W])) * int'(win[r][c]);
        if (sum < 0) sum = 0;
        if (sum > 255) sum = 255;
        res.pixel_out = 8'(sum);
      end
      res.last_of_frame = (out_row + 1 >= h) && (out_col + 1 >= w);
      expected_pixels.push_back(res);
      if (res.last_of_frame) begin
        restart();
      end else if (out_col + 1 >= w) begin
        out_col = 0;
        out_row++;
      end else begin
        out_col++;
      end
    endfunction

    function void check_result(c3f_out_t got);
      c3f_out_t want;
      if (expected_pixels.size() == 0) begin
        errors++;
        $error("unexpected word: pixel_out %0d last_of_frame %0b",
               got.pixel_out, got.last_of_frame);
        return;
      end
      want = expected_pixels.pop_front();
      if (got.pixel_out !== want.pixel_out) begin
        errors++;
        $error("pixel_out expected %0d actual %0d", want.pixel_out, got.pixel_out);
      end
      if (got.last_of_frame !== want.last_of_frame) begin
        errors++;
        $error("last_of_frame expected %0b actual %0b",
               want.last_of_frame, got.last_of_frame);
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  c3f_in_t                    in_data = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  c3f_out_t                   out_data;
  logic                       cfg_we = 1'b0;
  logic [C3F_CFG_IDX_W-1:0]   cfg_index = '0;
  logic [C3F_KROW_W-1:0]      cfg_wdata = '0;

  conv_scoreboard sb = new();

  // Sender runs with no gaps while this is set
  bit          back_to_back = 1'b0;
  int unsigned stall_left = 0;
  int unsigned steady_left = 0;
  int          next_stall;
  int unsigned quiet_cycles = 0;

  conv3x3_saturating_filter_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Gap length shared by both sides: mostly none or short, now and then long
  function automatic int gap_len();
    int roll;
    roll = int'($urandom_range(0, 99));
    if (roll < 55) return 0;
    if (roll < 85) return int'($urandom_range(1, 3));
    if (roll < 97) return int'($urandom_range(4, 12));
    return int'($urandom_range(20, 60));
  endfunction

  // Lean on the pixel extremes so that clamping and copies see 0 and 255 often
  function automatic logic [7:0] pick_pixel();
    int roll;
    roll = int'($urandom_range(0, 99));
    if (roll < 10) return 8'h00;
    if (roll < 20) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [C3F_COEF_W-1:0] pick_coef();
    int roll;
    roll = int'($urandom_range(0, 99));
    if (roll < 15) return 16'h7FFF;
    if (roll < 30) return 16'h8000;
    if (roll < 40) return 16'hFFFF;
    if (roll < 50) return 16'h0000;
    if (roll < 70) return 16'($urandom_range(0, 16)) - 16'd8;
    return 16'($urandom());
  endfunction

  // Mostly tiny frames so that many frames fit; a few reach 40 columns
  function automatic logic [C3F_DIM_W-1:0] pick_dim();
    int roll;
    roll = int'($urandom_range(0, 99));
    if (roll < 5) return '0;
    if (roll < 15) return 11'd1;
    if (roll < 25) return 11'd2;
    if (roll < 70) return 11'($urandom_range(3, 6));
    if (roll < 92) return 11'($urandom_range(7, 16));
    return 11'($urandom_range(17, 40));
  endfunction

  // Receiver: random stalls, with occasional long stretches of steady ready
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (steady_left != 0) begin
      out_ready   <= 1'b1;
      steady_left <= steady_left - 1;
    end else if ($urandom_range(0, 24) == 0) begin
      out_ready   <= 1'b1;
      steady_left <= $urandom_range(30, 150);
    end else begin
      next_stall = gap_len();
      if (next_stall == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready  <= 1'b0;
        stall_left <= next_stall - 1;
      end
    end
  end

  // Check every result word on the edge that accepts it
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // Watchdog: a stuck handshake ends the run
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Present one word after a random gap and hold it until accepted
  task automatic send_word(input logic op, input logic [7:0] px);
    c3f_in_t word;
    int      gap;
    word.operation = op;
    word.pixel_in  = px;
    gap = back_to_back ? 0 : gap_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= word;
    do @(posedge clk); while (!in_ready);
    sb.take_word(word);
  endtask

  // Write one register; the block takes it on the edge with cfg_we high
  task automatic write_reg(input logic [C3F_CFG_IDX_W-1:0] idx,
                           input logic [C3F_KROW_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    sb.write_reg(idx, value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold the sender until every expected word is out, then idle a while longer
  task automatic settle(input int extra);
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // One frame at the current geometry followed by W+1 flush words. Sprinkle
  // drains among the pixels (the block swallows them) and stray pixels among
  // the flush words (they flush like drains). A cut-short frame stops early
  // and leaves the abort to a geometry write.
  task automatic run_frame(input bit cut_short);
    int unsigned w, h, pixels, total, stop_at;
    w = sb.eff_w();
    h = sb.eff_h();
    pixels  = w * h;
    total   = pixels + w + 1;
    stop_at = cut_short ? $urandom_range(1, total - 1) : total;
    back_to_back = ($urandom_range(0, 3) == 0);
    for (int unsigned k = 0; k < stop_at; k++) begin
      if (k < pixels) begin
        if ($urandom_range(0, 19) == 0) send_word(C3F_OP_DRAIN, pick_pixel());
        if ($urandom_range(0, 199) == 0) settle(0);
        send_word(C3F_OP_PIXEL, pick_pixel());
      end else if ($urandom_range(0, 4) == 0) begin
        send_word(C3F_OP_PIXEL, pick_pixel());
      end else begin
        send_word(C3F_OP_DRAIN, pick_pixel());
      end
    end
    back_to_back = 1'b0;
  endtask

  initial begin
    logic [7:0]           board [9];
    logic [C3F_DIM_W-1:0] w_raw;
    bit                   cut;

    board = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00};
    cut = 1'b0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Writes past the last register must change nothing
    for (int i = NUM_CFG_REGS; i < (1 << C3F_CFG_IDX_W); i++)
      write_reg(C3F_CFG_IDX_W'(i), {C3F_KROW_W{1'b1}});

    // 3x3 checkerboard with the reset kernel: the center saturates high.
    // A drain in mid-frame is swallowed, a pixel in the flush acts as a drain.
    write_reg(C3F_REG_WIDTH, 48'd3);
    write_reg(C3F_REG_HEIGHT, 48'd3);
    for (int i = 0; i < 9; i++) begin
      if (i == 4) send_word(C3F_OP_DRAIN, 8'hA5);
      send_word(C3F_OP_PIXEL, board[i]);
    end
    send_word(C3F_OP_DRAIN, 8'h00);
    send_word(C3F_OP_DRAIN, 8'hFF);
    send_word(C3F_OP_PIXEL, 8'hFF);
    send_word(C3F_OP_DRAIN, 8'h5A);
    settle(SETTLE_CYCLES);

    // Extreme coefficients, then abort the frame half way with a width write
    write_reg(C3F_REG_KTOP, 48'h7FFF_8000_7FFF);
    write_reg(C3F_REG_KMID, 48'h8000_7FFF_8000);
    write_reg(C3F_REG_KBOT, 48'h7FFF_8000_7FFF);
    repeat (5) send_word(C3F_OP_PIXEL, 8'hFF);
    settle(SETTLE_CYCLES);

    // Zero width clamps to one: a 1x2 frame is all border
    write_reg(C3F_REG_WIDTH, 48'd0);
    write_reg(C3F_REG_HEIGHT, 48'd2);
    send_word(C3F_OP_PIXEL, 8'h80);
    send_word(C3F_OP_PIXEL, 8'h7F);
    send_word(C3F_OP_DRAIN, 8'h00);
    send_word(C3F_OP_DRAIN, 8'h00);
    settle(SETTLE_CYCLES);

    // Random frames; a cut-short frame is always followed by a geometry write
    while (sb.consumed < STREAM_GOAL) begin
      if (cut || $urandom_range(0, 2) == 0) begin
        if ($urandom_range(0, 9) == 0)
          write_reg(C3F_REG_HEIGHT, C3F_KROW_W'($urandom_range(0, 2047)));
        w_raw = pick_dim();
        write_reg(C3F_REG_WIDTH, C3F_KROW_W'(w_raw));
        if (w_raw > 16) write_reg(C3F_REG_HEIGHT, C3F_KROW_W'($urandom_range(1, 6)));
        else write_reg(C3F_REG_HEIGHT, C3F_KROW_W'(pick_dim()));
      end
      if ($urandom_range(0, 2) == 0)
        write_reg(C3F_REG_KTOP, {pick_coef(), pick_coef(), pick_coef()});
      if ($urandom_range(0, 2) == 0)
        write_reg(C3F_REG_KMID, {pick_coef(), pick_coef(), pick_coef()});
      if ($urandom_range(0, 2) == 0)
        write_reg(C3F_REG_KBOT, {pick_coef(), pick_coef(), pick_coef()});
      cut = ($urandom_range(0, 9) == 0);
      run_frame(cut);
      settle(SETTLE_CYCLES);
    end

    // Tallest frame: oversize height clamps to the maximum
    write_reg(C3F_REG_WIDTH, 48'd1);
    write_reg(C3F_REG_HEIGHT, 48'd2047);
    run_frame(1'b0);
    settle(SETTLE_CYCLES);

    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
